// File: sv/ib32_pkg.sv
`default_nettype none

package ib32_pkg;

  // result kinds as seen on the output channel
  localparam logic [1:0] KIND_DATA    = 2'd0;
  localparam logic [1:0] KIND_INVALID = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
  localparam logic [7:0] CHAR_LOW_A   = 8'h61;
  localparam logic [7:0] CHAR_LOW_Z   = 8'h7a;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_FIVE    = 8'h35;
  localparam logic [4:0] DIGIT_BASE   = 5'd26;

  localparam logic [7:0] PAD_LOW  = 8'h00;
  localparam logic [7:0] PAD_HIGH = 8'h80;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = 1;
  localparam int QUEUE_CW    = 2;

  typedef enum logic [1:0] {
    OP_BYTES,
    OP_INVALID,
    OP_END
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [7:0] b0;
    logic [7:0] b1;
    logic       two;
  } cmd_t;

  function automatic logic char_in_alphabet(input logic [7:0] c);
    char_in_alphabet = ((c >= CHAR_LOW_A) && (c <= CHAR_LOW_Z)) ||
                       ((c >= CHAR_ZERO) && (c <= CHAR_FIVE));
  endfunction

  function automatic logic [4:0] char_to_code(input logic [7:0] c);
    logic [7:0] diff;
    if ((c >= CHAR_LOW_A) && (c <= CHAR_LOW_Z)) begin
      diff = c - CHAR_LOW_A;
      char_to_code = diff[4:0];
    end else begin
      diff = c - CHAR_ZERO;
      char_to_code = diff[4:0] + DIGIT_BASE;
    end
  endfunction

  // even bit then odd bit, msb first
  function automatic logic [9:0] interleave(input logic [4:0] ev, input logic [4:0] od);
    logic [9:0] r;
    for (int k = 0; k < 5; k++) begin
      r[2*k+1] = ev[k];
      r[2*k]   = od[k];
    end
    interleave = r;
  endfunction

  function automatic logic is_pad(input logic [7:0] b);
    is_pad = (b == PAD_LOW) || (b == PAD_HIGH);
  endfunction

endpackage

`default_nettype wire

// File: sv/ib32_if.sv
`default_nettype none

interface ib32_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_stream;

  modport source (output valid, output char_code, output end_of_stream, input ready);
  modport sink   (input valid, input char_code, input end_of_stream, output ready);
endinterface

interface ib32_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic [1:0] kind;
  logic       last_of_run;

  modport source (output valid, output byte_value, output kind, output last_of_run,
                  input ready);
  modport sink   (input valid, input byte_value, input kind, input last_of_run,
                  output ready);
endinterface

`default_nettype wire

// File: sv/ib32_front.sv
`default_nettype none

module ib32_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  ib32_in_if.sink            in_chan,
  input  wire logic          q_full,
  output      logic          q_push,
  output      ib32_pkg::cmd_t q_cmd
);
  import ib32_pkg::*;

  logic [4:0] held_r, held_nxt;
  logic       have_even_r, have_even_nxt;
  logic [6:0] left_bits_r, left_bits_nxt;
  logic [2:0] left_cnt_r, left_cnt_nxt;

  logic        accept;
  logic        valid_char;
  logic [4:0]  code;
  logic [16:0] acc;
  logic [4:0]  cnt;
  logic        two;
  logic [4:0]  sh0;
  logic [4:0]  sh1;
  logic [4:0]  rem_cnt;
  logic [16:0] shifted0;
  logic [16:0] shifted1;
  logic [16:0] rem_mask;

  assign in_chan.ready = !q_full;
  assign accept        = in_chan.valid && !q_full;
  assign valid_char    = char_in_alphabet(in_chan.char_code);
  assign code          = char_to_code(in_chan.char_code);

  // pair the codes and cut whole bytes off the bit accumulator
  assign acc      = {left_bits_r, interleave(held_r, code)};
  assign cnt      = {2'b00, left_cnt_r} + 5'd10;
  assign two      = cnt >= 5'd16;
  assign sh0      = cnt - 5'd8;
  assign sh1      = cnt - 5'd16;
  assign shifted0 = acc >> sh0;
  assign shifted1 = acc >> sh1;
  assign rem_cnt  = two ? sh1 : sh0;
  assign rem_mask = (17'd1 << rem_cnt) - 17'd1;

  // classify the character and build the command
  always_comb begin
    q_push        = 1'b0;
    q_cmd.op      = OP_BYTES;
    q_cmd.b0      = shifted0[7:0];
    q_cmd.b1      = shifted1[7:0];
    q_cmd.two     = two;
    held_nxt      = held_r;
    have_even_nxt = have_even_r;
    left_bits_nxt = left_bits_r;
    left_cnt_nxt  = left_cnt_r;
    if (accept) begin
      priority if (in_chan.end_of_stream) begin
        q_push        = 1'b1;
        q_cmd.op      = OP_END;
        held_nxt      = 5'd0;
        have_even_nxt = 1'b0;
        left_bits_nxt = 7'd0;
        left_cnt_nxt  = 3'd0;
      end else if (in_chan.char_code == CHAR_NEWLINE) begin
        q_push = 1'b0;
      end else if (!valid_char) begin
        q_push   = 1'b1;
        q_cmd.op = OP_INVALID;
      end else if (!have_even_r) begin
        held_nxt      = code;
        have_even_nxt = 1'b1;
      end else begin
        q_push        = 1'b1;
        held_nxt      = 5'd0;
        have_even_nxt = 1'b0;
        left_bits_nxt = acc[6:0] & rem_mask[6:0];
        left_cnt_nxt  = rem_cnt[2:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= 5'd0;
      have_even_r <= 1'b0;
      left_bits_r <= 7'd0;
      left_cnt_r  <= 3'd0;
    end else begin
      held_r      <= held_nxt;
      have_even_r <= have_even_nxt;
      left_bits_r <= left_bits_nxt;
      left_cnt_r  <= left_cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// File: sv/ib32_cmd_queue.sv
`default_nettype none

module ib32_cmd_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire ib32_pkg::cmd_t push_cmd,
  output      logic           full,
  output      logic           head_valid,
  output      ib32_pkg::cmd_t head_cmd,
  input  wire logic           pop
);
  import ib32_pkg::*;

  cmd_t                mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_CW-1:0] count_r;
  logic                do_push, do_pop;

  assign full       = count_r == QUEUE_CW'(QUEUE_DEPTH);
  assign head_valid = count_r != '0;
  assign head_cmd   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/ib32_back.sv
`default_nettype none

module ib32_back #(
  parameter int PENDING_DEPTH = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           head_valid,
  input  wire ib32_pkg::cmd_t head_cmd,
  output      logic           pop,
  ib32_out_if.source          out_chan
);
  import ib32_pkg::*;

  localparam int CNT_W = $clog2(PENDING_DEPTH + 1);

  // held padding bytes, oldest at bit 0, one bit says 128 rather than 0
  logic [PENDING_DEPTH-1:0] pad_r, pad_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     sel_r, sel_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic [1:0] out_kind_r;
  logic       out_last_r;

  logic                     out_free;
  logic                     emit;
  logic [7:0]               e_byte;
  logic [1:0]               e_kind;
  logic                     e_last;
  logic                     advance;
  logic [7:0]               cur_byte;
  logic                     cur_pad;
  logic                     last_byte;
  logic                     cnt_full;
  logic                     cnt_near;
  logic                     b1_silent;
  logic                     final_here;
  logic [7:0]               oldest_byte;
  logic [PENDING_DEPTH:0]   ext_cur;
  logic [PENDING_DEPTH:0]   ext_zero;
  logic [PENDING_DEPTH-1:0] slot_sel;

  assign out_free    = !out_valid_r || out_chan.ready;
  assign cur_byte    = sel_r ? head_cmd.b1 : head_cmd.b0;
  assign cur_pad     = is_pad(cur_byte);
  assign last_byte   = sel_r || !head_cmd.two;
  assign cnt_full    = cnt_r == CNT_W'(PENDING_DEPTH);
  assign cnt_near    = cnt_r == CNT_W'(PENDING_DEPTH - 1);
  assign oldest_byte = pad_r[0] ? PAD_HIGH : PAD_LOW;
  assign ext_cur     = {cur_byte == PAD_HIGH, pad_r};
  assign ext_zero    = {1'b0, pad_r};

  // second byte gives nothing when it is padding and the queue still has room
  assign b1_silent  = is_pad(head_cmd.b1) &&
                      !(is_pad(head_cmd.b0) && (cnt_full || cnt_near));
  assign final_here = last_byte || b1_silent;

  always_comb begin
    for (int i = 0; i < PENDING_DEPTH; i++) begin
      slot_sel[i] = cnt_r == CNT_W'(i);
    end
  end

  // one step of the current command per cycle; a step that emits waits until the output register is free
  always_comb begin
    emit    = 1'b0;
    e_byte  = 8'd0;
    e_kind  = KIND_DATA;
    e_last  = 1'b0;
    advance = 1'b0;
    pop     = 1'b0;
    cnt_nxt = cnt_r;
    pad_nxt = pad_r;
    sel_nxt = sel_r;
    if (head_valid) begin
      unique case (head_cmd.op)
        OP_END: begin
          emit   = 1'b1;
          e_kind = KIND_END;
          e_last = 1'b1;
          if (out_free) begin
            cnt_nxt = '0;
            pop     = 1'b1;
            sel_nxt = 1'b0;
          end
        end
        OP_INVALID: begin
          emit   = 1'b1;
          e_kind = KIND_INVALID;
          e_last = 1'b1;
          if (out_free) begin
            pop     = 1'b1;
            sel_nxt = 1'b0;
          end
        end
        OP_BYTES: begin
          if (cur_pad) begin
            if (cnt_full) begin
              // overflow: oldest goes out, new one joins at the tail
              emit   = 1'b1;
              e_byte = oldest_byte;
              e_last = final_here;
              if (out_free) begin
                pad_nxt = ext_cur[PENDING_DEPTH:1];
                advance = 1'b1;
              end
            end else begin
              pad_nxt = (pad_r & ~slot_sel) |
                        (slot_sel & {PENDING_DEPTH{cur_byte == PAD_HIGH}});
              cnt_nxt = cnt_r + 1'b1;
              advance = 1'b1;
            end
          end else if (cnt_r != '0) begin
            // drain held padding ahead of a real byte
            emit   = 1'b1;
            e_byte = oldest_byte;
            if (out_free) begin
              pad_nxt = ext_zero[PENDING_DEPTH:1];
              cnt_nxt = cnt_r - 1'b1;
            end
          end else begin
            emit   = 1'b1;
            e_byte = cur_byte;
            e_last = final_here;
            advance = out_free;
          end
          if (advance) begin
            if (last_byte) begin
              pop     = 1'b1;
              sel_nxt = 1'b0;
            end else begin
              sel_nxt = 1'b1;
            end
          end
        end
        default: begin
          pop = 1'b1;
        end
      endcase
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pad_r <= pad_nxt;
    if (emit && out_free) begin
      out_byte_r <= e_byte;
      out_kind_r <= e_kind;
      out_last_r <= e_last;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.byte_value  = out_byte_r;
  assign out_chan.kind        = out_kind_r;
  assign out_chan.last_of_run = out_last_r;

endmodule

`default_nettype wire

// File: sv/interleaved_base32_text_decoder.sv
// channel   direction  payload                               handshake
// in_chan   input      char_code[7:0], end_of_stream         valid/ready
// out_chan  output     byte_value[7:0], kind[1:0], last_of_run  valid/ready
//
// an input character is taken whenever the two-entry command queue has room
// the back end drains up to PENDING_DEPTH held padding bytes ahead of a real byte,
// one byte per step, and each step that emits waits for a free output register
// reset is synchronous, active low; held padding storage needs no clearing
// a stalled output holds its result and the queue back-pressures the input

`default_nettype none

module interleaved_base32_text_decoder #(
  parameter int PENDING_DEPTH = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ib32_in_if.sink   in_chan,
  ib32_out_if.source out_chan
);
  import ib32_pkg::*;

  logic q_push, q_full, q_head_valid, q_pop;
  cmd_t q_push_cmd, q_head_cmd;

  // character classification and bit packing
  ib32_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_cmd   (q_push_cmd)
  );

  ib32_cmd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_push_cmd),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head_cmd   (q_head_cmd),
    .pop        (q_pop)
  );

  // padding hold-back and result emission
  ib32_back #(
    .PENDING_DEPTH (PENDING_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_cmd   (q_head_cmd),
    .pop        (q_pop),
    .out_chan   (out_chan)
  );

endmodule

`default_nettype wire

// File: sv/ib32_checker.sv
`default_nettype none

module ib32_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte_value,
  input wire logic [1:0] out_kind,
  input wire logic       out_last_of_run
);
  import ib32_pkg::*;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // no kind code beyond end of stream
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == KIND_DATA || out_kind == KIND_INVALID ||
                   out_kind == KIND_END))
    else $error("unknown result kind");

  // invalid and end results are single results with a zero byte
  a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_INVALID || out_kind == KIND_END) |->
      (out_byte_value == 8'd0) && out_last_of_run)
    else $error("status result malformed");

  // a data byte that is not last is followed by more data of the same run
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_kind == KIND_DATA && !out_last_of_run |=>
      !out_valid || out_kind == KIND_DATA)
    else $error("run broken by a status result");

endmodule

bind interleaved_base32_text_decoder ib32_checker u_ib32_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_byte_value  (out_chan.byte_value),
  .out_kind        (out_chan.kind),
  .out_last_of_run (out_chan.last_of_run)
);

`default_nettype wire

// File: tb/tb_interleaved_base32_text_decoder.sv
`default_nettype none

import ib32_pkg::*;

// one result transaction on the output channel
typedef struct packed {
  logic [7:0] byte_value;
  logic [1:0] kind;
  logic       last_of_run;
} decoded_result_t;

// tracks the decoder state and the results still owed by the block
class decode_scoreboard;
  int unsigned     pad_depth;
  logic [4:0]      held_even_code;
  bit              have_even;
  logic [6:0]      spare_bits;
  int unsigned     spare_count;
  bit              held_pad_high[$];
  decoded_result_t awaited[$];
  decoded_result_t run_results[$];
  int unsigned     failures;

  function new(int unsigned depth);
    pad_depth = depth;
    failures  = 0;
    clear_stream();
  endfunction

  function void clear_stream();
    held_even_code = '0;
    have_even      = 1'b0;
    spare_bits     = '0;
    spare_count    = 0;
    held_pad_high.delete();
  endfunction

  function void add_result(logic [7:0] value, logic [1:0] kind);
    decoded_result_t r;
    r.byte_value  = value;
    r.kind        = kind;
    r.last_of_run = 1'b0;
    run_results.push_back(r);
  endfunction

  // padding bytes wait until a real byte shows up, oldest spills on overflow
  function void release_byte(logic [7:0] value);
    if (value == PAD_LOW || value == PAD_HIGH) begin
      if (held_pad_high.size() >= pad_depth)
        add_result(held_pad_high.pop_front() ? PAD_HIGH : PAD_LOW, KIND_DATA);
      held_pad_high.push_back(value == PAD_HIGH);
    end else begin
      while (held_pad_high.size() > 0)
        add_result(held_pad_high.pop_front() ? PAD_HIGH : PAD_LOW, KIND_DATA);
      add_result(value, KIND_DATA);
    end
  endfunction

  // accepted input transaction: work out the results it causes
  function void note_input(logic [7:0] c, logic eos);
    logic [7:0]      offset;
    logic [4:0]      code;
    logic [9:0]      chunk;
    logic [16:0]     acc;
    logic [16:0]     shifted;
    logic [16:0]     kept;
    int unsigned     cnt;
    decoded_result_t tail;
    run_results.delete();
    if (eos) begin
      clear_stream();
      add_result(8'h00, KIND_END);
    end else if (c == CHAR_NEWLINE) begin
      // newline is skipped silently
    end else if ((c >= CHAR_LOW_A && c <= CHAR_LOW_Z) || (c >= CHAR_ZERO && c <= CHAR_FIVE)) begin
      if (c >= CHAR_LOW_A)
        offset = c - CHAR_LOW_A;
      else
        offset = c - CHAR_ZERO + 8'd26;
      code = offset[4:0];
      if (!have_even) begin
        held_even_code = code;
        have_even      = 1'b1;
      end else begin
        // interleave even and odd code bits, msb first
        chunk = '0;
        for (int k = 4; k >= 0; k--)
          chunk = {chunk[7:0], held_even_code[k], code[k]};
        have_even      = 1'b0;
        held_even_code = '0;
        acc = {spare_bits, chunk};
        cnt = spare_count + 10;
        while (cnt >= 8) begin
          shifted = acc >> (cnt - 8);
          release_byte(shifted[7:0]);
          cnt -= 8;
        end
        kept        = acc & ((17'd1 << cnt) - 17'd1);
        spare_bits  = kept[6:0];
        spare_count = cnt;
      end
    end else begin
      add_result(8'h00, KIND_INVALID);
    end
    if (run_results.size() > 0) begin
      tail = run_results.pop_back();
      tail.last_of_run = 1'b1;
      run_results.push_back(tail);
    end
    foreach (run_results[i])
      awaited.push_back(run_results[i]);
  endfunction

  function void note_failure(string msg);
    failures++;
    if (failures <= 10)
      $display("[%0t] %s", $time, msg);
  endfunction

  // accepted output transaction against the oldest expectation
  function void check_result(logic [7:0] value, logic [1:0] kind, logic last);
    decoded_result_t want;
    if (awaited.size() == 0) begin
      note_failure($sformatf("unexpected result byte=%02h kind=%0d last=%0b",
                             value, kind, last));
    end else begin
      want = awaited.pop_front();
      if (want.byte_value !== value || want.kind !== kind || want.last_of_run !== last)
        note_failure($sformatf(
          "result mismatch: expected byte=%02h kind=%0d last=%0b, got byte=%02h kind=%0d last=%0b",
          want.byte_value, want.kind, want.last_of_run, value, kind, last));
    end
  endfunction

  function void finish_check();
    if (awaited.size() > 0)
      note_failure($sformatf("%0d expected results never arrived", awaited.size()));
  endfunction
endclass

module tb_interleaved_base32_text_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import ib32_pkg::*;

  localparam int PENDING_DEPTH = 16;
  localparam int RANDOM_ITEMS  = 400;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 80;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_stream;
  } text_item_t;

  typedef enum int {
    READY_ALWAYS,
    READY_RANDOM,
    READY_PERIODIC,
    READY_SPARSE
  } stall_mode_t;

  typedef enum int {
    GEN_GROUP,
    GEN_PAD_RUN,
    GEN_END,
    GEN_RAW_CHAR,
    GEN_NOISE,
    GEN_LONE_CHAR
  } gen_kind_t;

  logic clk;
  logic rst_n;

  ib32_in_if  in_if ();
  ib32_out_if out_if ();

  interleaved_base32_text_decoder #(
    .PENDING_DEPTH(PENDING_DEPTH)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if),
    .out_chan(out_if)
  );

  decode_scoreboard sb;
  text_item_t       char_stream[$];
  logic [7:0]       byte_group[$];
  int unsigned      cycle_count = 0;

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // observe both channels
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready)
      sb.note_input(in_if.char_code, in_if.end_of_stream);
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_result(out_if.byte_value, out_if.kind, out_if.last_of_run);
  end

  // receiver back-pressure, switching pattern every so often
  initial begin
    stall_mode_t stall_mode;
    int unsigned phase_left;
    out_if.ready = 1'b0;
    stall_mode   = READY_ALWAYS;
    phase_left   = 0;
    forever begin
      @(negedge clk);
      if (phase_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        phase_left = $urandom_range(20, 120);
      end
      phase_left--;
      case (stall_mode)
        READY_ALWAYS:   out_if.ready = 1'b1;
        READY_RANDOM:   out_if.ready = ($urandom_range(0, 9) < 7);
        READY_PERIODIC: out_if.ready = ((cycle_count % 4) != 0);
        default:        out_if.ready = ($urandom_range(0, 9) < 3);
      endcase
    end
  end

  function automatic void push_item(logic [7:0] c, logic eos);
    text_item_t t;
    t.char_code     = c;
    t.end_of_stream = eos;
    char_stream.push_back(t);
  endfunction

  // any byte outside the alphabet other than newline
  function automatic logic [7:0] pick_invalid();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(0, 9));
      1:       return 8'($urandom_range(11, 47));
      2:       return 8'($urandom_range(54, 96));
      default: return 8'($urandom_range(123, 255));
    endcase
  endfunction

  // mostly padding values, sometimes anything
  function automatic logic [7:0] pick_pad_biased();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4)
      return PAD_LOW;
    else if (r < 6)
      return PAD_HIGH;
    else
      return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] char_of_code(logic [4:0] code);
    if (code < 5'd26)
      return CHAR_LOW_A + 8'(code);
    else
      return CHAR_ZERO + 8'(code - 5'd26);
  endfunction

  function automatic void maybe_noise(bit noisy);
    if (noisy && $urandom_range(0, 19) == 0)
      push_item($urandom_range(0, 1) ? CHAR_NEWLINE : pick_invalid(), 1'b0);
  endfunction

  // turn the wanted bytes into character pairs, topping up the last chunk with random bits
  function automatic void push_byte_group(bit noisy);
    bit         bit_stream[$];
    logic [9:0] chunk;
    logic [4:0] ev;
    logic [4:0] od;
    foreach (byte_group[i])
      for (int b = 7; b >= 0; b--)
        bit_stream.push_back(byte_group[i][b]);
    while (bit_stream.size() % 10 != 0)
      bit_stream.push_back(1'($urandom_range(0, 1)));
    while (bit_stream.size() > 0) begin
      for (int k = 9; k >= 0; k--)
        chunk[k] = bit_stream.pop_front();
      for (int k = 0; k < 5; k++) begin
        ev[k] = chunk[2*k+1];
        od[k] = chunk[2*k];
      end
      push_item(char_of_code(ev), 1'b0);
      maybe_noise(noisy);
      push_item(char_of_code(od), 1'b0);
      maybe_noise(noisy);
    end
    byte_group.delete();
  endfunction

  // present one transaction and hold it until the block takes it
  task automatic send_item(input text_item_t t);
    in_if.valid         = 1'b1;
    in_if.char_code     = t.char_code;
    in_if.end_of_stream = t.end_of_stream;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
  endtask

  // main sequence
  initial begin
    string       directed_text;
    int unsigned target;
    gen_kind_t   gen_kind;
    int unsigned pads;
    logic [7:0]  value;
    int unsigned idx;
    int unsigned burst;
    int unsigned gap;

    sb = new(PENDING_DEPTH);
    rst_n               = 1'b0;
    in_if.valid         = 1'b0;
    in_if.char_code     = 8'h00;
    in_if.end_of_stream = 1'b0;

    // directed: end with a character present, invalid extremes, newline,
    // alphabet edges, padding release, an unpaired char dropped by end
    push_item(8'hff, 1'b1);
    push_item(8'h00, 1'b0);
    push_item(8'hff, 1'b0);
    push_item(CHAR_NEWLINE, 1'b0);
    directed_text = "/6`{a55az0qaaazzaaq";
    for (int i = 0; i < directed_text.len(); i++)
      push_item(directed_text[i], 1'b0);
    push_item(CHAR_NEWLINE, 1'b0);
    push_item(8'h00, 1'b1);

    // random: byte groups with random content, padding runs, end items, raw characters, noise and broken pairs
    target = char_stream.size() + RANDOM_ITEMS;
    gen_kind = GEN_PAD_RUN;
    while (char_stream.size() < target) begin
      case (gen_kind)
        GEN_GROUP: begin
          for (int i = 0; i < 5; i++)
            byte_group.push_back(pick_pad_biased());
          push_byte_group(1'b1);
        end
        GEN_PAD_RUN: begin
          // enough padding to overflow the hold queue, then a real byte
          pads = $urandom_range(PENDING_DEPTH + 1, PENDING_DEPTH + 6);
          for (int i = 0; i < pads; i++)
            byte_group.push_back($urandom_range(0, 1) ? PAD_HIGH : PAD_LOW);
          do value = 8'($urandom_range(1, 255)); while (value == PAD_HIGH);
          byte_group.push_back(value);
          while (byte_group.size() % 5 != 0)
            byte_group.push_back(pick_pad_biased());
          push_byte_group(1'b0);
        end
        GEN_END: push_item(8'($urandom_range(0, 255)), 1'b1);
        GEN_RAW_CHAR: begin
          push_item(8'($urandom_range(0, 255)), 1'b0);
          if ($urandom_range(0, 1))
            push_item(8'($urandom_range(0, 255)), 1'b1);
        end
        GEN_NOISE: push_item($urandom_range(0, 1) ? CHAR_NEWLINE : pick_invalid(), 1'b0);
        default: begin
          // unpaired character dropped by the end transaction
          push_item(8'($urandom_range(CHAR_LOW_A, CHAR_LOW_Z)), 1'b0);
          push_item(8'($urandom_range(0, 255)), 1'b1);
        end
      endcase
      case ($urandom_range(0, 99)) inside
        [0:59]:  gen_kind = GEN_GROUP;
        [60:69]: gen_kind = GEN_PAD_RUN;
        [70:79]: gen_kind = GEN_END;
        [80:87]: gen_kind = GEN_RAW_CHAR;
        [88:93]: gen_kind = GEN_NOISE;
        default: gen_kind = GEN_LONE_CHAR;
      endcase
    end

    // reset
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // sender bursts with gaps, long unbroken stretches now and then
    idx = 0;
    while (idx < char_stream.size()) begin
      if ($urandom_range(0, 3) == 0)
        burst = $urandom_range(30, 90);
      else
        burst = $urandom_range(1, 10);
      while (burst > 0 && idx < char_stream.size()) begin
        send_item(char_stream[idx]);
        idx++;
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        in_if.valid = 1'b0;
        repeat (gap) begin
          in_if.char_code     = 8'($urandom_range(0, 255));
          in_if.end_of_stream = 1'($urandom_range(0, 1));
          @(negedge clk);
        end
      end
    end
    in_if.valid = 1'b0;

    // wait for the block to catch up
    while (sb.awaited.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.finish_check();

    if (sb.failures == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// File: interleaved_base32_text_decoder.f
sv/ib32_pkg.sv
sv/ib32_if.sv
sv/ib32_front.sv
sv/ib32_cmd_queue.sv
sv/ib32_back.sv
sv/interleaved_base32_text_decoder.sv
sv/ib32_checker.sv
tb/tb_interleaved_base32_text_decoder.sv
